// ===== rtl/core/hwt_pkg.sv =====
// Shared constants, codes and types of the hashed timing wheel.
package hwt_pkg;

  localparam int TIMER_ENTRIES_DEF = 32;
  localparam int WHEEL_SLOTS_DEF   = 64;

  localparam int ID_W     = 32;
  localparam int DELAY_W  = 32;
  localparam int ROUNDS_W = 31;
  localparam int KIND_W   = 3;
  localparam int PEND_W   = 7;
  localparam int REQ_W    = 2;
  localparam int TICK_W   = 16;
  localparam int SLOTS_W  = 7;
  localparam int CFG_W    = 16;
  localparam int CFG_IX_W = 1;
  localparam int DIV_W    = 32;

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE      = 3'd5;

  localparam logic [CFG_IX_W-1:0] CFG_TICK_MS = 1'd0;
  localparam logic [CFG_IX_W-1:0] CFG_SLOTS   = 1'd1;

  localparam logic [TICK_W-1:0]  TICK_MS_RESET = 16'd10;
  localparam logic [SLOTS_W-1:0] SLOTS_RESET   = 7'd64;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/core/hwt_req_if.sv =====
// Request channel: valid, ready and the request payload.
interface hwt_req_if;
  logic                              valid;
  logic                              ready;
  logic [hwt_pkg::REQ_W-1:0]         req_type;
  logic signed [hwt_pkg::DELAY_W-1:0] timeout_ms;
  logic [hwt_pkg::ID_W-1:0]          cancel_id;

  modport source (output valid, output req_type, output timeout_ms, output cancel_id,
                  input ready);
  modport sink (input valid, input req_type, input timeout_ms, input cancel_id,
                output ready);
endinterface

// ===== rtl/core/hwt_res_if.sv =====
// Result channel: valid, ready and the result payload.
interface hwt_res_if;
  logic                       valid;
  logic                       ready;
  logic [hwt_pkg::KIND_W-1:0] result_kind;
  logic [hwt_pkg::ID_W-1:0]   task_id;
  logic [hwt_pkg::PEND_W-1:0] pending_count;
  logic                       last;

  modport source (output valid, output result_kind, output task_id, output pending_count,
                  output last, input ready);
  modport sink (input valid, input result_kind, input task_id, input pending_count,
                input last, output ready);
endinterface

// ===== rtl/core/hwt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module hwt_div (
  input  logic              clk,
  input  logic              rst,
  input  hwt_pkg::div_req_t req,
  output hwt_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(hwt_pkg::DIV_W + 1);

  logic [hwt_pkg::DIV_W-1:0] rem;
  logic [hwt_pkg::DIV_W-1:0] quo;
  logic [hwt_pkg::DIV_W-1:0] dvs;
  logic [CNT_W-1:0]          cnt;
  logic                      done;
  logic [hwt_pkg::DIV_W:0]   trial;

  assign trial = {rem, quo[hwt_pkg::DIV_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
        cnt <= CNT_W'(hwt_pkg::DIV_W);
      end else if (cnt != '0) begin
        if (!trial[hwt_pkg::DIV_W]) begin
          rem <= trial[hwt_pkg::DIV_W-1:0];
          quo <= {quo[hwt_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem <= {rem[hwt_pkg::DIV_W-2:0], quo[hwt_pkg::DIV_W-1]};
          quo <= {quo[hwt_pkg::DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule

// ===== rtl/core/hashed_timing_wheel.sv =====
// Hashed timing wheel with rounds over a small table of timer entries.
// A user sends add, cancel and tick requests and receives one result per add or
// cancel and one or more results per tick, the final one flagged by last. The
// block takes one request at a time. A cancel compares one entry per cycle, then
// answers. Each division runs on the shared divider. An add scans for the lowest
// free entry, then runs three divisions and places its result; a rejected add
// ends after the scan. A tick runs one division and one pass over the table, and
// then gives a none result for an empty slot or, per expired timer, passes over
// the table once more to pick the lowest id. A result waiting in the output
// register does not stop a new request from being taken; the block only waits
// where it must place its next result.
module hashed_timing_wheel #(
  parameter int TIMER_ENTRIES = hwt_pkg::TIMER_ENTRIES_DEF,
  parameter int WHEEL_SLOTS   = hwt_pkg::WHEEL_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  hwt_req_if.sink                      req,
  hwt_res_if.source                    res,
  input  logic                         cfg_we,
  input  logic [hwt_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [hwt_pkg::CFG_W-1:0]    cfg_data
);

  localparam int IX_W   = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
  localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  localparam int ES_W   = $clog2(WHEEL_SLOTS + 1);
  localparam int CNT_W  = $clog2(TIMER_ENTRIES + 1);
  localparam logic [IX_W-1:0] IX_LAST = IX_W'(TIMER_ENTRIES - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FREE  = 4'd1;
  localparam logic [3:0] ST_D1    = 4'd2;
  localparam logic [3:0] ST_D2    = 4'd3;
  localparam logic [3:0] ST_D3    = 4'd4;
  localparam logic [3:0] ST_AOUT  = 4'd5;
  localparam logic [3:0] ST_CAN   = 4'd6;
  localparam logic [3:0] ST_COUT  = 4'd7;
  localparam logic [3:0] ST_TDIV  = 4'd8;
  localparam logic [3:0] ST_TSCAN = 4'd9;
  localparam logic [3:0] ST_TNONE = 4'd10;
  localparam logic [3:0] ST_TMIN  = 4'd11;
  localparam logic [3:0] ST_TOUT  = 4'd12;

  // Configuration registers.
  logic [hwt_pkg::TICK_W-1:0]  tick_ms;
  logic [hwt_pkg::SLOTS_W-1:0] slots_cfg;
  logic [hwt_pkg::TICK_W-1:0]  eff_tick;
  logic [ES_W-1:0]             eff_slots;

  // Timer table. Valid and expiry marks are flip-flops cleared by reset.
  logic [TIMER_ENTRIES-1:0]      e_valid;
  logic [TIMER_ENTRIES-1:0]      e_exp;
  logic [SLOT_W-1:0]             e_slot   [TIMER_ENTRIES];
  logic [hwt_pkg::ROUNDS_W-1:0]  e_rounds [TIMER_ENTRIES];
  logic [hwt_pkg::ID_W-1:0]      e_id     [TIMER_ENTRIES];

  logic [3:0]                    state;
  logic [IX_W-1:0]               ix;
  logic [IX_W-1:0]               sel_ix;
  logic                          found;
  logic [hwt_pkg::ID_W-1:0]      best_id;
  logic [SLOT_W-1:0]             cur;
  logic [SLOT_W-1:0]             new_slot;
  logic [hwt_pkg::ROUNDS_W-1:0]  new_rounds;
  logic [hwt_pkg::DIV_W-1:0]     ticks;
  logic [hwt_pkg::DIV_W-1:0]     ticks_next;
  logic [hwt_pkg::ID_W-1:0]      next_id;
  logic [CNT_W-1:0]              live_count;
  logic [CNT_W-1:0]              exp_cnt;
  logic [hwt_pkg::DELAY_W-1:0]   delay;
  logic [hwt_pkg::ID_W-1:0]      cid;

  // Output register.
  logic                          o_valid;
  logic [hwt_pkg::KIND_W-1:0]    o_kind;
  logic [hwt_pkg::ID_W-1:0]      o_id;
  logic [hwt_pkg::PEND_W-1:0]    o_pend;
  logic                          o_last;
  logic                          out_free;

  hwt_pkg::div_req_t div_req;
  hwt_pkg::div_rsp_t div_rsp;

  hwt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // A zero tick length counts as one; the slot count is clamped to the built wheel.
  always_comb begin
    eff_tick = (tick_ms == '0) ? hwt_pkg::TICK_W'(1) : tick_ms;
    if (slots_cfg == '0) begin
      eff_slots = ES_W'(1);
    end else if (32'(slots_cfg) > WHEEL_SLOTS) begin
      eff_slots = ES_W'(WHEEL_SLOTS);
    end else begin
      eff_slots = ES_W'(slots_cfg);
    end
  end

  // Whole ticks rounded up, and never fewer than one.
  always_comb begin
    ticks_next = div_rsp.quot + hwt_pkg::DIV_W'(div_rsp.rem != '0);
    if (ticks_next == '0) ticks_next = hwt_pkg::DIV_W'(1);
  end

  assign out_free  = !o_valid || res.ready;
  assign req.ready = (state == ST_IDLE);

  assign res.valid         = o_valid;
  assign res.result_kind   = o_kind;
  assign res.task_id       = o_id;
  assign res.pending_count = o_pend;
  assign res.last          = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms   <= hwt_pkg::TICK_MS_RESET;
      slots_cfg <= hwt_pkg::SLOTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hwt_pkg::CFG_TICK_MS: tick_ms   <= cfg_data;
        hwt_pkg::CFG_SLOTS:   slots_cfg <= cfg_data[hwt_pkg::SLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      e_valid       <= '0;
      e_exp         <= '0;
      cur           <= '0;
      next_id       <= hwt_pkg::ID_W'(1);
      live_count    <= '0;
      exp_cnt       <= '0;
      o_valid       <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (res.ready) o_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          ix <= '0;
          if (req.valid) begin
            delay <= req.timeout_ms;
            cid   <= req.cancel_id;
            unique case (req.req_type)
              hwt_pkg::REQ_ADD:    state <= ST_FREE;
              hwt_pkg::REQ_CANCEL: state <= ST_CAN;
              hwt_pkg::REQ_TICK: begin
                div_req.start    <= 1'b1;
                div_req.dividend <= hwt_pkg::DIV_W'(cur) + hwt_pkg::DIV_W'(1);
                div_req.divisor  <= hwt_pkg::DIV_W'(eff_slots);
                state            <= ST_TDIV;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        // Lowest free entry, one entry per cycle.
        ST_FREE: begin
          ix <= ix + 1'b1;
          if (!e_valid[ix]) begin
            found            <= 1'b1;
            sel_ix           <= ix;
            div_req.start    <= 1'b1;
            div_req.dividend <= delay[hwt_pkg::DELAY_W-1] ? '0 : delay;
            div_req.divisor  <= hwt_pkg::DIV_W'(eff_tick);
            state            <= ST_D1;
          end else if (ix == IX_LAST) begin
            found <= 1'b0;
            state <= ST_AOUT;
          end
        end
        ST_D1: begin
          if (div_rsp.done) begin
            ticks            <= ticks_next;
            div_req.start    <= 1'b1;
            div_req.dividend <= ticks_next - hwt_pkg::DIV_W'(1);
            div_req.divisor  <= hwt_pkg::DIV_W'(eff_slots);
            state            <= ST_D2;
          end
        end
        ST_D2: begin
          if (div_rsp.done) begin
            new_rounds       <= div_rsp.quot[hwt_pkg::ROUNDS_W-1:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= hwt_pkg::DIV_W'(cur) + ticks;
            div_req.divisor  <= hwt_pkg::DIV_W'(eff_slots);
            state            <= ST_D3;
          end
        end
        ST_D3: begin
          if (div_rsp.done) begin
            new_slot <= div_rsp.rem[SLOT_W-1:0];
            state    <= ST_AOUT;
          end
        end
        ST_AOUT: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_last  <= 1'b1;
            if (found) begin
              e_valid[sel_ix]  <= 1'b1;
              e_slot[sel_ix]   <= new_slot;
              e_rounds[sel_ix] <= new_rounds;
              e_id[sel_ix]     <= next_id;
              next_id          <= next_id + 1'b1;
              live_count       <= live_count + 1'b1;
              o_kind           <= hwt_pkg::KIND_ADDED;
              o_id             <= next_id;
              o_pend           <= hwt_pkg::PEND_W'(live_count + 1'b1);
            end else begin
              o_kind <= hwt_pkg::KIND_FULL;
              o_id   <= '0;
              o_pend <= hwt_pkg::PEND_W'(live_count);
            end
            state <= ST_IDLE;
          end
        end
        // First live entry with the requested id.
        ST_CAN: begin
          ix <= ix + 1'b1;
          if (e_valid[ix] && e_id[ix] == cid) begin
            found  <= 1'b1;
            sel_ix <= ix;
            state  <= ST_COUT;
          end else if (ix == IX_LAST) begin
            found <= 1'b0;
            state <= ST_COUT;
          end
        end
        ST_COUT: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_last  <= 1'b1;
            o_id    <= '0;
            if (found) begin
              e_valid[sel_ix] <= 1'b0;
              live_count      <= live_count - 1'b1;
              o_kind          <= hwt_pkg::KIND_CANCELLED;
              o_pend          <= hwt_pkg::PEND_W'(live_count - 1'b1);
            end else begin
              o_kind <= hwt_pkg::KIND_NOT_FOUND;
              o_pend <= hwt_pkg::PEND_W'(live_count);
            end
            state <= ST_IDLE;
          end
        end
        ST_TDIV: begin
          if (div_rsp.done) begin
            cur     <= div_rsp.rem[SLOT_W-1:0];
            exp_cnt <= '0;
            state   <= ST_TSCAN;
          end
        end
        // Entries in the new slot lose a round or are marked as expired.
        ST_TSCAN: begin
          ix <= (ix == IX_LAST) ? '0 : ix + 1'b1;
          if (e_valid[ix] && e_slot[ix] == cur) begin
            if (e_rounds[ix] != '0) begin
              e_rounds[ix] <= e_rounds[ix] - 1'b1;
            end else begin
              e_exp[ix] <= 1'b1;
              exp_cnt   <= exp_cnt + 1'b1;
            end
          end
          if (ix == IX_LAST) begin
            found <= 1'b0;
            if (exp_cnt == '0 && !(e_valid[ix] && e_slot[ix] == cur && e_rounds[ix] == '0)) begin
              state <= ST_TNONE;
            end else begin
              state <= ST_TMIN;
            end
          end
        end
        ST_TNONE: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_last  <= 1'b1;
            o_kind  <= hwt_pkg::KIND_NONE;
            o_id    <= '0;
            o_pend  <= hwt_pkg::PEND_W'(live_count);
            state   <= ST_IDLE;
          end
        end
        // Smallest id among marked entries; a strict compare keeps the lower index on ties.
        ST_TMIN: begin
          ix <= (ix == IX_LAST) ? '0 : ix + 1'b1;
          if (e_exp[ix] && (!found || e_id[ix] < best_id)) begin
            found   <= 1'b1;
            sel_ix  <= ix;
            best_id <= e_id[ix];
          end
          if (ix == IX_LAST) state <= ST_TOUT;
        end
        ST_TOUT: begin
          if (out_free) begin
            e_valid[sel_ix] <= 1'b0;
            e_exp[sel_ix]   <= 1'b0;
            live_count      <= live_count - 1'b1;
            exp_cnt         <= exp_cnt - 1'b1;
            o_valid         <= 1'b1;
            o_kind          <= hwt_pkg::KIND_EXPIRED;
            o_id            <= best_id;
            o_pend          <= hwt_pkg::PEND_W'(live_count - 1'b1);
            o_last          <= (exp_cnt == CNT_W'(1));
            found           <= 1'b0;
            ix              <= '0;
            state           <= (exp_cnt == CNT_W'(1)) ? ST_IDLE : ST_TMIN;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The number of live timers never exceeds the table.
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    32'(live_count) <= TIMER_ENTRIES)
    else $error("live count above table size");

  // The expiry count matches the marked entries while results are emitted.
  a_exp_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TMIN || state == ST_TOUT) |-> $countones(e_exp) == 32'(exp_cnt))
    else $error("expiry count out of step with marks");

  // The divider only finishes while the sequencer waits on it.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_D1 || state == ST_D2 || state == ST_D3 ||
                      state == ST_TDIV))
    else $error("divider result with nobody waiting");

  // Each expired result removes exactly one live timer.
  a_expire_dec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TOUT && out_free) |=> live_count == $past(live_count) - 1'b1)
    else $error("expiry did not remove one timer");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the hashed timing wheel: directed tests, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = hwt_pkg::TIMER_ENTRIES_DEF;
  localparam int SLOTS_MAX = hwt_pkg::WHEEL_SLOTS_DEF;

  // The watchdog allows this many cycles in which neither channel completes a transfer.
  // The longest quiet stretch of a correct run is the settling pause before a register
  // write.
  localparam int STALL_LIMIT = 20000;
  // Cycles allowed to pass before a register write, so that an ignored request has
  // certainly left the block.
  localparam int SETTLE_CYCLES = 200;

  localparam logic [hwt_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct {
    logic [hwt_pkg::KIND_W-1:0] kind;
    logic [hwt_pkg::ID_W-1:0]   id;
    logic [hwt_pkg::PEND_W-1:0] pend;
    logic                       last;
  } wheel_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [hwt_pkg::CFG_IX_W-1:0] cfg_index;
  logic [hwt_pkg::CFG_W-1:0] cfg_data;

  hwt_req_if req_ch ();
  hwt_res_if res_ch ();

  hashed_timing_wheel dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the wheel: registers, timer table and counters.
  logic [hwt_pkg::TICK_W-1:0]   sh_tick_ms;
  logic [hwt_pkg::SLOTS_W-1:0]  sh_slots;
  logic                         sh_valid [ENTRIES];
  logic [5:0]                   sh_slot  [ENTRIES];
  logic [hwt_pkg::ROUNDS_W-1:0] sh_rounds[ENTRIES];
  logic [hwt_pkg::ID_W-1:0]     sh_id    [ENTRIES];
  logic [5:0]                   sh_cur;
  logic [hwt_pkg::ID_W-1:0]     sh_next_id;
  int                           sh_live;

  // Results predicted but not yet seen on the result channel, oldest first.
  wheel_result_t due_results[$];

  int errors;
  int checked;
  int n_added, n_full, n_cancelled, n_not_found, n_expired, n_none;
  int idle_cycles;
  int burst_left;
  bit quiet_sender;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Effective register values, with the out-of-range settings folded in.
  function automatic longint unsigned eff_tick();
    return (sh_tick_ms == '0) ? 1 : longint'(sh_tick_ms);
  endfunction

  function automatic longint unsigned eff_slots();
    if (sh_slots == '0) return 1;
    if (sh_slots > SLOTS_MAX) return SLOTS_MAX;
    return longint'(sh_slots);
  endfunction

  function automatic void push_result(logic [hwt_pkg::KIND_W-1:0] kind,
                                      logic [hwt_pkg::ID_W-1:0] id);
    wheel_result_t r;
    r.kind = kind;
    r.id   = id;
    r.pend = hwt_pkg::PEND_W'(sh_live);
    r.last = 1'b0;
    due_results = {due_results, r};
  endfunction

  // Applies one accepted request to the shadow wheel and queues what it must produce.
  function automatic void wheel_predict(logic [hwt_pkg::REQ_W-1:0] rtype,
                                        logic [hwt_pkg::DELAY_W-1:0] delay,
                                        logic [hwt_pkg::ID_W-1:0] cid);
    longint unsigned slots, t, dly, ticks;
    int free_ix, hit, cnt, v, b;
    int order[ENTRIES];
    slots = eff_slots();
    if (rtype == hwt_pkg::REQ_ADD) begin
      t = eff_tick();
      dly = delay[hwt_pkg::DELAY_W-1] ? 0 : longint'(delay);
      ticks = (dly + t - 1) / t;
      if (ticks == 0) ticks = 1;
      free_ix = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!sh_valid[i]) begin
          free_ix = i;
          break;
        end
      end
      if (free_ix < 0) begin
        push_result(hwt_pkg::KIND_FULL, '0);
        n_full++;
      end else begin
        sh_valid[free_ix]  = 1'b1;
        sh_slot[free_ix]   = 6'((longint'(sh_cur) + ticks) % slots);
        sh_rounds[free_ix] = hwt_pkg::ROUNDS_W'((ticks - 1) / slots);
        sh_id[free_ix]     = sh_next_id;
        sh_next_id++;
        sh_live++;
        push_result(hwt_pkg::KIND_ADDED, sh_id[free_ix]);
        n_added++;
      end
    end else if (rtype == hwt_pkg::REQ_CANCEL) begin
      hit = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (sh_valid[i] && sh_id[i] == cid) begin
          hit = i;
          break;
        end
      end
      if (hit < 0) begin
        push_result(hwt_pkg::KIND_NOT_FOUND, '0);
        n_not_found++;
      end else begin
        sh_valid[hit] = 1'b0;
        sh_live--;
        push_result(hwt_pkg::KIND_CANCELLED, '0);
        n_cancelled++;
      end
    end else if (rtype == hwt_pkg::REQ_TICK) begin
      sh_cur = 6'((longint'(sh_cur) + 1) % slots);
      cnt = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (sh_valid[i] && sh_slot[i] == sh_cur) begin
          if (sh_rounds[i] > 0) sh_rounds[i]--;
          else order[cnt++] = i;
        end
      end
      // Stable sort by id, so that equal ids keep their entry order.
      for (int a = 1; a < cnt; a++) begin
        v = order[a];
        b = a - 1;
        while (b >= 0 && sh_id[order[b]] > sh_id[v]) begin
          order[b + 1] = order[b];
          b--;
        end
        order[b + 1] = v;
      end
      if (cnt == 0) begin
        push_result(hwt_pkg::KIND_NONE, '0);
        n_none++;
      end else begin
        for (int a = 0; a < cnt; a++) begin
          sh_valid[order[a]] = 1'b0;
          sh_live--;
          push_result(hwt_pkg::KIND_EXPIRED, sh_id[order[a]]);
          n_expired++;
        end
      end
    end else begin
      return;
    end
    due_results[$].last = 1'b1;
  endfunction

  // Sends one request and waits for its transfer. The valid line stays high into the
  // next request unless the sender takes a gap here.
  task automatic send_req(logic [hwt_pkg::REQ_W-1:0] rtype,
                          logic [hwt_pkg::DELAY_W-1:0] delay,
                          logic [hwt_pkg::ID_W-1:0] cid);
    int gap;
    @(negedge clk);
    req_ch.valid      = 1'b1;
    req_ch.req_type   = rtype;
    req_ch.timeout_ms = delay;
    req_ch.cancel_id  = cid;
    forever begin
      @(posedge clk);
      if (req_ch.ready) break;
    end
    wheel_predict(rtype, delay, cid);
    if (burst_left > 0) begin
      burst_left--;
    end else if (!quiet_sender) begin
      burst_left = $urandom_range(0, 6);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    wait (due_results.size() == 0);
  endtask

  // Registers are only written with the block idle.
  task automatic write_reg(logic [hwt_pkg::CFG_IX_W-1:0] ix,
                           logic [hwt_pkg::CFG_W-1:0] data);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = ix;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (ix == hwt_pkg::CFG_TICK_MS) sh_tick_ms = data[hwt_pkg::TICK_W-1:0];
    else sh_slots = data[hwt_pkg::SLOTS_W-1:0];
  endtask

  task automatic cancel_all();
    logic [hwt_pkg::ID_W-1:0] ids[$];
    for (int i = 0; i < ENTRIES; i++) if (sh_valid[i]) ids = {ids, sh_id[i]};
    foreach (ids[k]) send_req(hwt_pkg::REQ_CANCEL, $urandom, ids[k]);
  endtask

  function automatic logic [hwt_pkg::ID_W-1:0] pick_live_id();
    int picks[$];
    for (int i = 0; i < ENTRIES; i++) if (sh_valid[i]) picks = {picks, i};
    if (picks.size() == 0) return sh_next_id;
    return sh_id[picks[$urandom_range(0, picks.size() - 1)]];
  endfunction

  task automatic report_mismatch(string field, logic [hwt_pkg::ID_W-1:0] got,
                                 logic [hwt_pkg::ID_W-1:0] want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  // Checks every result transfer against the oldest prediction.
  always @(posedge clk) begin
    wheel_result_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      checked++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, kind", hwt_pkg::ID_W'(res_ch.result_kind), '0);
      end else begin
        w = due_results.pop_front();
        if (res_ch.result_kind !== w.kind)
          report_mismatch("result_kind", hwt_pkg::ID_W'(res_ch.result_kind),
                          hwt_pkg::ID_W'(w.kind));
        if (res_ch.task_id !== w.id) report_mismatch("task_id", res_ch.task_id, w.id);
        if (res_ch.pending_count !== w.pend)
          report_mismatch("pending_count", hwt_pkg::ID_W'(res_ch.pending_count),
                          hwt_pkg::ID_W'(w.pend));
        if (res_ch.last !== w.last)
          report_mismatch("last", hwt_pkg::ID_W'(res_ch.last), hwt_pkg::ID_W'(w.last));
      end
    end
  end

  // The receiver cycles through three habits: always ready, random refusals, and stalls.
  int stall_left;
  int rx_phase;
  initial begin
    res_ch.ready = 1'b0;
    stall_left = 0;
    rx_phase = 0;
    forever begin
      @(negedge clk);
      rx_phase++;
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case ((rx_phase / 400) % 3)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 1) == 1);
          default: begin
            res_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
          end
        endcase
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("[hashed_timing_wheel] ERROR");
        $finish;
      end
    end
  end

  // Default registers: every delay extreme, both ways to miss a cancel, an ignored
  // request and an empty tick.
  task automatic test_defaults();
    send_req(hwt_pkg::REQ_TICK, '0, '0);
    send_req(hwt_pkg::REQ_ADD, 32'h8000_0000, '0);
    send_req(hwt_pkg::REQ_ADD, 32'hFFFF_FFFF, '0);
    send_req(hwt_pkg::REQ_ADD, 32'd0, '0);
    send_req(hwt_pkg::REQ_ADD, 32'd1, '0);
    send_req(hwt_pkg::REQ_ADD, 32'd10, '0);
    send_req(hwt_pkg::REQ_ADD, 32'd11, '0);
    send_req(hwt_pkg::REQ_ADD, 32'h7FFF_FFFF, '0);
    send_req(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(hwt_pkg::REQ_CANCEL, '0, 32'd0);
    send_req(hwt_pkg::REQ_CANCEL, '0, 32'hFFFF_FFFF);
    send_req(hwt_pkg::REQ_CANCEL, '0, 32'd6);
    send_req(hwt_pkg::REQ_CANCEL, '0, 32'd6);
    send_req(hwt_pkg::REQ_TICK, '0, '0);
    send_req(hwt_pkg::REQ_TICK, '0, '0);
    cancel_all();
  endtask

  // With a single slot in use, fills the table, shows that a further add is turned
  // away without using an id, and that a freed entry is taken again.
  task automatic test_full_table();
    write_reg(hwt_pkg::CFG_SLOTS, 16'd1);
    for (int i = 0; i < ENTRIES; i++) send_req(hwt_pkg::REQ_ADD, hwt_pkg::DELAY_W'(i % 2), '0);
    send_req(hwt_pkg::REQ_ADD, 32'd5, '0);
    send_req(hwt_pkg::REQ_CANCEL, '0, sh_id[3]);
    send_req(hwt_pkg::REQ_ADD, 32'd1, '0);
  endtask

  // With a tiny wheel many timers share one slot; entries reused out of id order
  // check the ascending expiry order and the round countdown.
  task automatic test_expiry_order();
    write_reg(hwt_pkg::CFG_TICK_MS, 16'd1);
    write_reg(hwt_pkg::CFG_SLOTS, 16'd2);
    for (int i = 0; i < 6; i++) send_req(hwt_pkg::REQ_ADD, 32'd2, '0);
    send_req(hwt_pkg::REQ_CANCEL, '0, sh_id[1]);
    send_req(hwt_pkg::REQ_CANCEL, '0, sh_id[0]);
    send_req(hwt_pkg::REQ_ADD, 32'd6, '0);
    send_req(hwt_pkg::REQ_ADD, 32'd2, '0);
    repeat (6) send_req(hwt_pkg::REQ_TICK, '0, '0);
    cancel_all();
  endtask

  // Every entry of the full table expiring on one tick.
  task automatic test_mass_expiry();
    send_req(hwt_pkg::REQ_TICK, '0, '0);
  endtask

  // Random traffic under one register setting. Most adds use delays that expire
  // within a few laps of the wheel, so ticks keep producing expiries.
  task automatic test_random(logic [hwt_pkg::CFG_W-1:0] tick_val,
                             logic [hwt_pkg::CFG_W-1:0] slots_val, int items);
    longint unsigned span;
    int pick;
    write_reg(hwt_pkg::CFG_TICK_MS, tick_val);
    write_reg(hwt_pkg::CFG_SLOTS, slots_val);
    quiet_sender = ($urandom_range(0, 2) == 0);
    span = eff_tick() * eff_slots() * 3;
    for (int n = 0; n < items; ) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if ($urandom_range(0, 9) == 0) send_req(hwt_pkg::REQ_ADD, $urandom, $urandom);
        else send_req(hwt_pkg::REQ_ADD, hwt_pkg::DELAY_W'($urandom_range(0, int'(span))),
                      $urandom);
        n++;
      end else if (pick < 62) begin
        if ($urandom_range(0, 9) < 7) send_req(hwt_pkg::REQ_CANCEL, $urandom, pick_live_id());
        else send_req(hwt_pkg::REQ_CANCEL, $urandom, $urandom);
        n++;
      end else if (pick < 96) begin
        send_req(hwt_pkg::REQ_TICK, $urandom, $urandom);
        n++;
      end else begin
        send_req(REQ_UNKNOWN, $urandom, $urandom);
      end
      // Now and then the sender holds off until the block has answered everything.
      if (n % 10 == 9) drain();
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    errors = 0;
    checked = 0;
    idle_cycles = 0;
    burst_left = 0;
    quiet_sender = 1'b0;
    n_added = 0; n_full = 0; n_cancelled = 0;
    n_not_found = 0; n_expired = 0; n_none = 0;
    req_ch.valid = 1'b0;
    req_ch.req_type = hwt_pkg::REQ_TICK;
    req_ch.timeout_ms = '0;
    req_ch.cancel_id = '0;
    cfg_we = 1'b0;
    cfg_index = hwt_pkg::CFG_TICK_MS;
    cfg_data = '0;
    sh_tick_ms = hwt_pkg::TICK_MS_RESET;
    sh_slots = hwt_pkg::SLOTS_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      sh_valid[i] = 1'b0;
      sh_slot[i] = '0;
      sh_rounds[i] = '0;
      sh_id[i] = '0;
    end
    sh_cur = '0;
    sh_next_id = 1;
    sh_live = 0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_defaults();
    test_expiry_order();
    test_full_table();
    test_mass_expiry();
    // Settings include the extremes and the out-of-range codes: a zero tick length,
    // zero slots and a slot count above the built size.
    test_random(16'd10, 16'd64, 15);
    test_random(16'd1, 16'd1, 15);
    test_random(16'd65535, 16'd64, 10);
    test_random(16'd0, 16'd0, 15);
    test_random(16'd3, 16'd127, 15);
    test_random(16'd2, 16'd5, 15);
    test_random(hwt_pkg::CFG_W'($urandom_range(1, 65535)),
                hwt_pkg::CFG_W'($urandom_range(1, 64)), 15);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered: %0d results checked; %0d added, %0d full, %0d cancelled, %0d missed",
             checked, n_added, n_full, n_cancelled, n_not_found);
    $display("covered: %0d expired, %0d empty ticks over seven register settings",
             n_expired, n_none);
    if (errors == 0 && due_results.size() == 0) begin
      $display("[hashed_timing_wheel] OK");
    end else begin
      $display("[hashed_timing_wheel] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/hwt_pkg.sv
rtl/core/hwt_req_if.sv
rtl/core/hwt_res_if.sv
rtl/core/hwt_div.sv
rtl/core/hashed_timing_wheel.sv
tb/tb_top.sv
